@@ rtl/ipct_pkg.sv @@
// shared types and request codes for the ip address packet counter table
`default_nettype none

package ipct_pkg;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 32;
    localparam int TOTAL_W = 9;

    localparam logic [1:0] REQ_COUNT = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] ip_addr;
    } t_req_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] hit_count;
        logic               was_present;
        logic [TOTAL_W-1:0] entry_total;
        logic               status;
    } t_rsp_beat;

    // table update issued by the control stage, at most one per cycle
    typedef struct packed {
        logic clear;
        logic insert;
        logic bump;
    } t_tbl_op;

endpackage

`default_nettype wire

@@ rtl/ipct_cam.sv @@
// address store with valid bits, parallel match and lowest free entry search
`default_nettype none

module ipct_cam
    import ipct_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tbl_op           i_op,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic      [DEPTH-1:0]  o_match_oh,
    output logic      [DEPTH-1:0]  o_free_oh,
    output logic                   o_full
);

    logic [DEPTH-1:0]  r_valid;
    logic [ADDR_W-1:0] r_addr [DEPTH];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            o_match_oh[i] = r_valid[i] && (r_addr[i] == i_addr);
        end
    end

    // lowest clear bit of the valid vector
    assign o_free_oh = ~r_valid & (r_valid + DEPTH'(1));
    assign o_full    = &r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_op.clear) begin
            r_valid <= '0;
        end else if (i_op.insert) begin
            r_valid <= r_valid | o_free_oh;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_op.insert && o_free_oh[i]) begin
                r_addr[i] <= i_addr;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_duplicate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_match_oh))
        else $error("address held in more than one entry");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.insert |-> ($onehot(o_free_oh) && (o_match_oh == '0)))
        else $error("insert without a single free entry or with a match");
`endif

endmodule

`default_nettype wire

@@ rtl/ipct_cnt.sv @@
// per-entry saturating packet counts with one-hot readout
`default_nettype none

module ipct_cnt
    import ipct_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire t_tbl_op            i_op,
    input  wire logic [DEPTH-1:0]   i_match_oh,
    input  wire logic [DEPTH-1:0]   i_free_oh,
    input  wire logic [DEPTH-1:0]   i_rd_sel,
    output logic      [COUNT_W-1:0] o_rd_data
);

    logic [COUNT_W-1:0] r_count [DEPTH];

    // each entry bumps in place, so no read is needed on the update path
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_op.insert && i_free_oh[i]) begin
                r_count[i] <= COUNT_W'(1);
            end else if (i_op.bump && i_match_oh[i] && (r_count[i] != '1)) begin
                r_count[i] <= r_count[i] + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        o_rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_rd_data = o_rd_data | (r_count[i] & {COUNT_W{i_rd_sel[i]}});
        end
    end

endmodule

`default_nettype wire

@@ rtl/ip_address_packet_counter_table.sv @@
// Per-address packet counter table: holds up to TABLE_DEPTH IPv4 addresses with counts.
// Requests arrive on the req channel (valid/ready, t_req_beat): count a packet from an
// address, query an address, or clear the whole table. Each request yields exactly one
// beat on the rsp channel (valid/ready, t_rsp_beat) in request order.
// Pipeline: input register, then lookup and table update, then count readout into the
// output register. Throughput is one request per cycle while rsp_ready stays high: the
// parallel address compare and the in-place counter update settle a request in a single
// step, so back-to-back hits on one address need no forwarding.
// Reset empties the table at once (valid bits cleared, entry count zero); there is no
// clearing pass and requests are taken from the first cycle after reset.
// When the receiver holds rsp_ready low the stages fill up and req_ready drops; nothing
// is lost and the table is not touched while the update stage is stalled.
// A count for a new address when every entry is taken returns status 1 and inserts nothing.
`default_nettype none

module ip_address_packet_counter_table
    import ipct_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_req_valid,
    output logic           o_req_ready,
    input  wire t_req_beat i_req,
    output logic           o_rsp_valid,
    input  wire logic      i_rsp_ready,
    output t_rsp_beat      o_rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic      r_v1;
    t_req_beat r_req1;

    logic                   r_v2;
    logic [TABLE_DEPTH-1:0] r_sel2;
    logic                   r_present2;
    logic                   r_status2;
    logic [TOTAL_W-1:0]     r_total2;

    logic      r_v3;
    t_rsp_beat r_rsp3;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [TABLE_DEPTH-1:0] match_oh;
    logic [TABLE_DEPTH-1:0] free_oh;
    logic                   full;
    logic                   hit;
    logic                   is_count;
    logic                   is_clear;
    logic                   step;
    t_tbl_op                op;
    logic [COUNT_W-1:0]     rd_data;

    assign rdy3 = !r_v3 || i_rsp_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_req_ready = rdy1;
    assign o_rsp_valid = r_v3;
    assign o_rsp       = r_rsp3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && rdy1) begin
            r_req1 <= i_req;
        end
    end

    ipct_cam #(
        .DEPTH (TABLE_DEPTH)
    ) u_cam (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_addr     (r_req1.ip_addr),
        .o_match_oh (match_oh),
        .o_free_oh  (free_oh),
        .o_full     (full)
    );

    // unused request code behaves as a query
    always_comb begin
        hit       = |match_oh;
        is_count  = (r_req1.req_type == REQ_COUNT);
        is_clear  = (r_req1.req_type == REQ_CLEAR);
        step      = r_v1 && rdy2;
        op.clear  = step && is_clear;
        op.insert = step && is_count && !hit && !full;
        op.bump   = step && is_count && hit;
        if (op.clear) begin
            n_cnt = '0;
        end else if (op.insert) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v2  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            if (is_clear) begin
                r_sel2 <= '0;
            end else if (op.insert) begin
                r_sel2 <= free_oh;
            end else begin
                r_sel2 <= match_oh;
            end
            r_present2 <= hit && !is_clear;
            r_status2  <= is_count && !hit && full;
            r_total2   <= TOTAL_W'(n_cnt);
        end
    end

    // counts read here already carry the update made by this beat
    ipct_cnt #(
        .DEPTH (TABLE_DEPTH)
    ) u_cnt (
        .i_clk      (i_clk),
        .i_op       (op),
        .i_match_oh (match_oh),
        .i_free_oh  (free_oh),
        .i_rd_sel   (r_sel2),
        .o_rd_data  (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_rsp3.hit_count   <= rd_data;
            r_rsp3.was_present <= r_present2;
            r_rsp3.entry_total <= r_total2;
            r_rsp3.status      <= r_status2;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $onehot0(r_sel2))
        else $error("readout select not one-hot");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status) |-> (!o_rsp.was_present && (o_rsp.hit_count == '0)))
        else $error("table full beat carries a hit");

    a_update_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !rdy3) |=> (r_cnt == $past(r_cnt)))
        else $error("table updated while update stage stalled");
`endif

endmodule

`default_nettype wire

@@ tb/ip_address_packet_counter_table_tb.sv @@
// self-checking testbench for the ip address packet counter table
`default_nettype none

module ip_address_packet_counter_table_tb;
    import ipct_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int RAND_ITEMS   = 1350;
    localparam int POOL_SIZE    = 300;
    localparam int SMALL_POOL   = 16;
    localparam int SEGMENT_LEN  = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 22;

    localparam logic [1:0]         REQ_SPARE = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [ADDR_W-1:0]  FILL_BASE = 32'h0A00_0000;

    typedef enum logic [0:0] {
        ROW_REQ,
        ROW_FILL
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] req_type;
        logic [ADDR_W-1:0] ip_addr;
        logic       known;
        t_rsp_beat  rsp;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_req_valid = 1'b0;
    t_req_beat i_req       = '0;
    logic      i_rsp_ready = 1'b0;
    logic      o_req_ready;
    logic      o_rsp_valid;
    t_rsp_beat o_rsp;

    // own copy of the table
    logic [ADDR_W-1:0]  tbl_addr  [TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];
    bit                 tbl_used  [TABLE_DEPTH];
    int                 tbl_entries = 0;

    t_rsp_beat          rsp_due_q [$];
    logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
    t_dir_row           dir_rows  [DIR_ROWS];

    int  mismatches = 0;
    int  stall_left = 0;
    int  cycles     = 0;
    bit  calm       = 1'b0;
    bit  hold_go    = 1'b0;
    bit  hold_rsp   = 1'b0;

    ip_address_packet_counter_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_rsp_beat apply_table_req(input t_req_beat beat);
        t_rsp_beat rsp;
        int hit_idx;
        int free_idx;
        rsp      = '0;
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_used[i] && tbl_addr[i] == beat.ip_addr && hit_idx < 0) begin
                hit_idx = i;
            end
            if (!tbl_used[i] && free_idx < 0) begin
                free_idx = i;
            end
        end
        case (beat.req_type)
            REQ_CLEAR: begin
                foreach (tbl_used[i]) tbl_used[i] = 1'b0;
                tbl_entries = 0;
            end
            REQ_COUNT: begin
                if (hit_idx >= 0) begin
                    rsp.was_present = 1'b1;
                    if (tbl_count[hit_idx] != COUNT_SAT) begin
                        tbl_count[hit_idx] = tbl_count[hit_idx] + 1'b1;
                    end
                    rsp.hit_count = tbl_count[hit_idx];
                end else if (free_idx >= 0) begin
                    tbl_addr[free_idx]  = beat.ip_addr;
                    tbl_count[free_idx] = COUNT_W'(1);
                    tbl_used[free_idx]  = 1'b1;
                    tbl_entries++;
                    rsp.hit_count = COUNT_W'(1);
                end else begin
                    rsp.status = 1'b1;
                end
            end
            default: begin
                // query, and the spare code behaves the same
                if (hit_idx >= 0) begin
                    rsp.was_present = 1'b1;
                    rsp.hit_count   = tbl_count[hit_idx];
                end
            end
        endcase
        rsp.entry_total = tbl_entries[TOTAL_W-1:0];
        return rsp;
    endfunction

    task automatic send_req(input t_req_beat beat, input logic known,
                            input t_rsp_beat known_rsp);
        t_rsp_beat predicted;
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= beat;
        do @(posedge i_clk); while (!o_req_ready);
        predicted = apply_table_req(beat);
        rsp_due_q.push_back(known ? known_rsp : predicted);
    endtask

    task automatic check_rsp(input t_rsp_beat got);
        t_rsp_beat want;
        if (rsp_due_q.size() == 0) begin
            if (mismatches < REPORT_MAX) begin
                $display("unexpected rsp beat: hit=%h pres=%b tot=%0d st=%b",
                         got.hit_count, got.was_present, got.entry_total, got.status);
            end
            mismatches++;
        end else begin
            want = rsp_due_q.pop_front();
            if (got.hit_count != want.hit_count || got.was_present != want.was_present ||
                got.entry_total != want.entry_total || got.status != want.status) begin
                if (mismatches < REPORT_MAX) begin
                    $display("rsp mismatch: exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                             want.hit_count, want.was_present, want.entry_total, want.status,
                             got.hit_count, got.was_present, got.entry_total, got.status);
                end
                mismatches++;
            end
        end
    endtask

    // response side: check the beat, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                check_rsp(o_rsp);
            end
            if (hold_rsp) begin
                i_rsp_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the request side
    initial begin
        wait (hold_go);
        repeat ($urandom_range(10, 60)) @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** ip_address_packet_counter_table: FAILED **");
        $finish;
    end

    initial begin
        t_req_beat beat;
        t_rsp_beat no_rsp;
        int psize;
        int roll;
        logic [ADDR_W-1:0] fill_addr;

        no_rsp    = '0;
        fill_addr = FILL_BASE;
        psize     = SMALL_POOL;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            addr_pool[i] = $urandom();
        end

        dir_rows = '{
            '{ROW_REQ,  REQ_QUERY, 32'h0000_0000, 1'b1, '{32'd0, 1'b0, 9'd0,   1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'h0000_0000, 1'b1, '{32'd1, 1'b0, 9'd1,   1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'hFFFF_FFFF, 1'b1, '{32'd1, 1'b0, 9'd2,   1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'hFFFF_FFFF, 1'b1, '{32'd2, 1'b1, 9'd2,   1'b0}},
            '{ROW_REQ,  REQ_QUERY, 32'hFFFF_FFFF, 1'b1, '{32'd2, 1'b1, 9'd2,   1'b0}},
            '{ROW_REQ,  REQ_SPARE, 32'h0000_0000, 1'b1, '{32'd1, 1'b1, 9'd2,   1'b0}},
            '{ROW_REQ,  REQ_QUERY, 32'h1234_5678, 1'b1, '{32'd0, 1'b0, 9'd2,   1'b0}},
            '{ROW_REQ,  REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 9'd0,   1'b0}},
            '{ROW_REQ,  REQ_QUERY, 32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 9'd0,   1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'h8000_0000, 1'b0, '0},
            '{ROW_REQ,  REQ_COUNT, 32'h7FFF_FFFF, 1'b0, '0},
            '{ROW_REQ,  REQ_COUNT, 32'h8000_0000, 1'b0, '0},
            '{ROW_REQ,  REQ_COUNT, 32'hAAAA_AAAA, 1'b0, '0},
            '{ROW_REQ,  REQ_COUNT, 32'h5555_5555, 1'b0, '0},
            '{ROW_REQ,  REQ_SPARE, 32'h5555_5555, 1'b0, '0},
            '{ROW_FILL, REQ_COUNT, 32'h0000_0000, 1'b0, '0},
            // table full: a new address is refused
            '{ROW_REQ,  REQ_COUNT, 32'hC0A8_0001, 1'b1, '{32'd0, 1'b0, 9'd256, 1'b1}},
            '{ROW_REQ,  REQ_QUERY, 32'hC0A8_0001, 1'b1, '{32'd0, 1'b0, 9'd256, 1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'h8000_0000, 1'b1, '{32'd3, 1'b1, 9'd256, 1'b0}},
            '{ROW_REQ,  REQ_SPARE, 32'h8000_0000, 1'b1, '{32'd3, 1'b1, 9'd256, 1'b0}},
            '{ROW_REQ,  REQ_CLEAR, 32'h0000_0000, 1'b1, '{32'd0, 1'b0, 9'd0,   1'b0}},
            '{ROW_REQ,  REQ_COUNT, 32'hC0A8_0001, 1'b1, '{32'd1, 1'b0, 9'd1,   1'b0}}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_FILL) begin
                // distinct new addresses until every entry is taken
                while (tbl_entries < TABLE_DEPTH) begin
                    beat.req_type = REQ_COUNT;
                    beat.ip_addr  = fill_addr;
                    fill_addr     = fill_addr + 1'b1;
                    send_req(beat, 1'b0, no_rsp);
                end
            end else begin
                beat.req_type = dir_rows[r].req_type;
                beat.ip_addr  = dir_rows[r].ip_addr;
                send_req(beat, dir_rows[r].known, dir_rows[r].rsp);
            end
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % SEGMENT_LEN == 0) begin
                calm  <= ($urandom_range(0, 3) == 0);
                psize  = ($urandom_range(0, 2) == 0) ? SMALL_POOL : POOL_SIZE;
            end
            if (k == 150) begin
                hold_go <= 1'b1;
            end
            roll = $urandom_range(0, 199);
            // clears only with the small pool, so the large pool can fill the table
            if (roll == 0 && psize == SMALL_POOL) begin
                beat.req_type = REQ_CLEAR;
            end else if (roll < 140) begin
                beat.req_type = REQ_COUNT;
            end else if (roll < 190) begin
                beat.req_type = REQ_QUERY;
            end else begin
                beat.req_type = REQ_SPARE;
            end
            if ($urandom_range(0, 9) == 0) begin
                beat.ip_addr = $urandom();
            end else begin
                beat.ip_addr = addr_pool[$urandom_range(0, psize - 1)];
            end
            send_req(beat, 1'b0, no_rsp);
        end
        i_req_valid <= 1'b0;

        while (rsp_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** ip_address_packet_counter_table: PASSED **");
        end else begin
            $display("** ip_address_packet_counter_table: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
